[sv/wva_pkg.sv]
// Shared types, constants and helpers of the wind vane averager.
`default_nettype none
package wva_pkg;

   // Angle scale: Q9.6 degrees
   localparam int unsigned FULL_TURN = 23040;
   localparam int unsigned HALF_TURN = 11520;

   // Shared divider sizing: widest numerator is pulses*1000, divisors fit 16 bits
   localparam int unsigned DIV_NW = 26;
   localparam int unsigned DIV_DW = 16;

   // Whole degrees: 360*raw/4095 = 8*raw/91; 8*ceil(2^21/91)/2^21, exact for 12-bit raw
   localparam int unsigned DEG_M  = 23046;
   localparam int unsigned DEG_SH = 18;

   // Knots per pulse-per-second, Q8.8, scaled by 10000
   localparam int unsigned SPD_K = 6220288;

   // Register indexes
   localparam logic [1:0] CSR_INVERTED = 2'd0;
   localparam logic [1:0] CSR_CENTRE   = 2'd1;
   localparam logic [1:0] CSR_SAMPLES  = 2'd2;

   // Operations of the shared divider
   typedef enum logic [1:0] {
      DIV_RATE = 2'd0,
      DIV_SPR  = 2'd1,
      DIV_AVG  = 2'd2
   } div_op_type;

   typedef struct packed {
      logic       cap_in;
      logic       loc_ld;
      logic       div_start;
      div_op_type div_op;
      logic       spd_mul;
      logic       dir_w;
      logic       dir_d;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // Wrap a signed angle in -69120..69119 into 0..23039
   function automatic logic [14:0] wrap_turn(input logic signed [18:0] x);
      logic signed [18:0] t;
      t = x;
      if (t < 0) t = t + 19'sd46080;
      if (t < 0) t = t + 19'sd23040;
      if (t >= 19'sd46080) t = t - 19'sd46080;
      if (t >= 19'sd23040) t = t - 19'sd23040;
      return t[14:0];
   endfunction

endpackage
`default_nettype wire

[sv/wva_ctrl.sv]
// Sequencing state machine of the wind vane averager.
`default_nettype none
module wva_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire wva_pkg::status_type status,
   output wva_pkg::cmd_type         cmd
);
   import wva_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_LOCAL    = 12'b000000000010,
      S_RATE_GO  = 12'b000000000100,
      S_RATE_WT  = 12'b000000001000,
      S_SPD      = 12'b000000010000,
      S_DIR_W    = 12'b000000100000,
      S_DIR_D    = 12'b000001000000,
      S_SPR_GO   = 12'b000010000000,
      S_SPR_WAIT = 12'b000100000000,
      S_AVG_GO   = 12'b001000000000,
      S_AVG_WAIT = 12'b010000000000,
      S_RESULT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.div_op    = DIV_RATE;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.cap_in = req_tvalid;
            if (req_tvalid) state_in = S_LOCAL;
         end
         S_LOCAL: begin
            cmd.loc_ld = 1'b1;
            state_in   = S_RATE_GO;
         end
         S_RATE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_RATE;
            state_in      = S_RATE_WT;
         end
         S_RATE_WT: if (status.div_done) state_in = S_SPD;
         S_SPD: begin
            cmd.spd_mul = 1'b1;
            state_in    = S_DIR_W;
         end
         S_DIR_W: begin
            cmd.dir_w = 1'b1;
            state_in  = S_DIR_D;
         end
         S_DIR_D: begin
            cmd.dir_d = 1'b1;
            state_in  = S_SPR_GO;
         end
         S_SPR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_SPR;
            state_in      = S_SPR_WAIT;
         end
         S_SPR_WAIT: if (status.div_done) state_in = S_AVG_GO;
         S_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_AVG;
            state_in      = S_AVG_WAIT;
         end
         S_AVG_WAIT: if (status.div_done) state_in = S_RESULT;
         S_RESULT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

[sv/wva_dp.sv]
// Datapath: config registers, shared divider, rate ring and averages.
`default_nettype none
module wva_dp #(
   parameter int unsigned SPEED_SAMPLES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic [11:0]         raw_angle,
   input  wire logic [15:0]         pulse_count,
   input  wire logic [15:0]         elapsed_ms,
   input  wire logic [14:0]         heading,
   input  wire wva_pkg::cmd_type    cmd,
   output wva_pkg::status_type      status,
   output logic [14:0]              local_direction,
   output logic [15:0]              wind_speed,
   output logic [14:0]              world_direction,
   output logic [13:0]              direction_spread
);
   import wva_pkg::*;

   localparam int unsigned PTR_W   = (SPEED_SAMPLES > 1) ? $clog2(SPEED_SAMPLES) : 1;
   localparam int unsigned SUM_W   = 24 + $clog2(SPEED_SAMPLES);
   localparam longint      SPD_DEN = longint'(SPEED_SAMPLES) * 10000;
   localparam longint      SPD_THR = (65536 * SPD_DEN + SPD_K - 1) / SPD_K;
   localparam int unsigned THR_W   = $clog2(SPD_THR);
   // Reciprocal of SPD_DEN folded into SPD_K; exact for every sum below SPD_THR
   localparam int unsigned SPD_SH  = THR_W + $clog2(SPD_DEN);
   localparam longint      SPD_M   = ((longint'(SPD_K) << SPD_SH) + SPD_DEN - 1) / SPD_DEN;
   localparam int unsigned SPD_M_W = $clog2(SPD_M + 1);
   localparam int unsigned PROD_W  = THR_W + SPD_M_W;

   // Config registers
   logic               inv_ff;
   logic signed [15:0] centre_ff;
   logic [7:0]         samples_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff     <= 1'b0;
         centre_ff  <= '0;
         samples_ff <= 8'd1;
      end else if (csr_we) begin
         if (csr_index == CSR_INVERTED) inv_ff     <= csr_wdata[0];
         if (csr_index == CSR_CENTRE)   centre_ff  <= csr_wdata;
         if (csr_index == CSR_SAMPLES)  samples_ff <= csr_wdata[7:0];
      end
   end

   // Captured transaction; vane reading becomes whole degrees on capture
   logic [8:0]  deg_ff;
   logic [26:0] deg_prod;
   logic [15:0] pulse_ff, elapsed_ff;
   logic [14:0] heading_ff;

   assign deg_prod = 27'(raw_angle) * 27'(DEG_M);

   always_ff @(posedge clock) begin
      if (cmd.cap_in) begin
         deg_ff     <= deg_prod[DEG_SH +: 9];
         pulse_ff   <= pulse_count;
         elapsed_ff <= elapsed_ms;
         heading_ff <= heading;
      end
   end

   // Shared restoring divider, one quotient bit per cycle
   logic [DIV_NW-1:0] quo_ff, num_in;
   logic [DIV_DW-1:0] rem_ff, den_ff, den_in;
   logic [5:0]        cnt_ff, iters_in;
   logic              done_ff;
   div_op_type        op_ff;
   logic [DIV_DW:0]   rem_sh, rem_diff;

   // Working values
   logic [21:0]       sprod;
   logic [13:0]       absd_ff;
   logic              dneg_ff;
   logic [7:0]        cnt_avg_ff, cnt_avg_in;
   logic [14:0]       w_ff;
   logic [13:0]       spread_ff;

   assign sprod = 22'(spread_ff) * 22'(cnt_avg_ff - 8'd1) + 22'(absd_ff);

   always_comb begin
      num_in   = '0;
      den_in   = '0;
      iters_in = '0;
      unique case (cmd.div_op)
         DIV_RATE: begin
            num_in   = 26'(pulse_ff) * 26'd1000;
            den_in   = (elapsed_ff == '0) ? 16'd1 : elapsed_ff;
            iters_in = 6'd26;
         end
         DIV_SPR: begin
            num_in   = {sprod, 4'd0};
            den_in   = 16'(cnt_avg_ff);
            iters_in = 6'd22;
         end
         DIV_AVG: begin
            num_in   = {absd_ff, 12'd0};
            den_in   = 16'(cnt_avg_ff);
            iters_in = 6'd14;
         end
         default: ;
      endcase
   end

   assign rem_sh   = {rem_ff, quo_ff[DIV_NW-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == 6'd1);
         if (cmd.div_start)      cnt_ff <= iters_in;
         else if (cnt_ff != '0)  cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= num_in;
         rem_ff <= '0;
         den_ff <= den_in;
         op_ff  <= cmd.div_op;
      end else if (cnt_ff != '0) begin
         if (!rem_diff[DIV_DW]) begin
            rem_ff <= rem_diff[DIV_DW-1:0];
            quo_ff <= {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_DW-1:0];
            quo_ff <= {quo_ff[DIV_NW-2:0], 1'b0};
         end
      end
   end

   assign status.div_done = done_ff;

   // Local direction from whole degrees
   logic [14:0]        local_ff, ang;
   logic signed [18:0] ang_s;
   assign ang   = {deg_ff, 6'd0};
   assign ang_s = (inv_ff ? -$signed({4'd0, ang}) : $signed({4'd0, ang}))
                  - 19'(centre_ff);

   // Rate ring: memory with registered read, valid bits for reset
   logic [23:0]              ring_mem [SPEED_SAMPLES];
   logic [23:0]              ring_rd_ff, rate_in;
   logic [SPEED_SAMPLES-1:0] vld_ff;
   logic [PTR_W-1:0]         pos_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W:0]           sum_in;
   logic [23:0]              old_rate;
   logic                     ring_upd;

   assign ring_upd = done_ff && (op_ff == DIV_RATE);
   assign rate_in  = (quo_ff[25:24] != 2'b00) ? 24'hFFFFFF : quo_ff[23:0];
   assign old_rate = vld_ff[pos_ff] ? ring_rd_ff : 24'd0;
   assign sum_in   = {1'b0, sum_ff} - (SUM_W+1)'(old_rate) + (SUM_W+1)'(rate_in);

   always_ff @(posedge clock) begin
      if (cmd.cap_in) ring_rd_ff <= ring_mem[pos_ff];
      if (ring_upd)   ring_mem[pos_ff] <= rate_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (ring_upd) begin
         vld_ff[pos_ff] <= 1'b1;
         sum_ff         <= sum_in[SUM_W-1:0];
         pos_ff         <= (pos_ff == PTR_W'(SPEED_SAMPLES - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   // Speed: saturate at the threshold, else multiply by the scaled reciprocal
   logic [15:0]       speed_ff;
   logic              spd_sat;
   logic [PROD_W-1:0] spd_prod;

   assign spd_sat  = (SUM_W+1)'(sum_ff) >= (SUM_W+1)'(SPD_THR);
   assign spd_prod = PROD_W'(sum_ff[THR_W-1:0]) * PROD_W'(SPD_M);

   always_ff @(posedge clock) begin
      if (cmd.loc_ld)  local_ff <= wrap_turn(ang_s);
      if (cmd.spd_mul) speed_ff <= spd_sat ? 16'hFFFF : 16'(spd_prod >> SPD_SH);
   end

   // Direction average state
   logic [14:0]        avg_ff;
   logic [14:0]        dwrap;
   logic signed [15:0] d_s;
   logic [13:0]        absd_in;
   logic signed [18:0] avg_sum;

   always_comb begin
      cnt_avg_in = (cnt_avg_ff < samples_ff) ? cnt_avg_ff + 8'd1 : cnt_avg_ff;
      if (cnt_avg_in == '0) cnt_avg_in = 8'd1;
   end

   assign dwrap   = wrap_turn($signed({4'd0, w_ff}) - $signed({4'd0, avg_ff})
                              + 19'sd34560);
   assign d_s     = $signed({1'b0, dwrap}) - 16'sd11520;
   assign absd_in = d_s[15] ? 14'(-d_s) : 14'(d_s);
   assign avg_sum = dneg_ff ? $signed({4'd0, avg_ff}) - $signed({5'd0, quo_ff[13:0]})
                            : $signed({4'd0, avg_ff}) + $signed({5'd0, quo_ff[13:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_avg_ff <= '0;
         avg_ff     <= '0;
         spread_ff  <= '0;
      end else begin
         if (cmd.dir_w) cnt_avg_ff <= cnt_avg_in;
         if (done_ff && op_ff == DIV_SPR) spread_ff <= quo_ff[13:0];
         if (done_ff && op_ff == DIV_AVG) avg_ff <= wrap_turn(avg_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dir_w) w_ff <= wrap_turn($signed({4'd0, heading_ff}) + $signed({4'd0, local_ff}));
      if (cmd.dir_d) begin
         absd_ff  <= absd_in;
         dneg_ff  <= d_s[15];
      end
   end

   assign local_direction  = local_ff;
   assign wind_speed       = speed_ff;
   assign world_direction  = avg_ff;
   assign direction_spread = spread_ff;

endmodule
`default_nettype wire

[sv/wind_vane_anemometer_averager_top.sv]
// Each transaction runs in order: local direction, a pass of the shared
// one-bit-per-cycle divider for the rate, speed, the two direction steps, then
// divider passes for the spread and the average, before rsp_tvalid. The next
// transaction is taken only after the result has been taken.
// Reset (synchronous, active high) clears the rate ring, averages and registers
// (samples_in_average to 1).
`default_nettype none
module wind_vane_anemometer_averager_top #(
   parameter int unsigned SPEED_SAMPLES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // raw_angle[11:0], pulse_count[27:12], elapsed_ms[43:28], heading[58:44]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // local_direction[14:0], wind_speed[30:15], world_direction[45:31],
   // direction_spread[59:46]
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import wva_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [14:0] local_direction, world_direction;
   logic [15:0] wind_speed;
   logic [13:0] direction_spread;

   wva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wva_dp #(.SPEED_SAMPLES(SPEED_SAMPLES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .raw_angle        (req_tdata[11:0]),
      .pulse_count      (req_tdata[27:12]),
      .elapsed_ms       (req_tdata[43:28]),
      .heading          (req_tdata[58:44]),
      .cmd              (cmd),
      .status           (status),
      .local_direction  (local_direction),
      .wind_speed       (wind_speed),
      .world_direction  (world_direction),
      .direction_spread (direction_spread)
   );

   assign rsp_tdata = {4'd0, direction_spread, world_direction, wind_speed, local_direction};

endmodule
`default_nettype wire
